// ----- rtl/rgb_median3x3_filter_unit_macros.svh -----
// Assertion helpers; clock clk, asynchronous reset arst_n.
`ifndef RGB_MEDIAN3X3_FILTER_UNIT_MACROS_SVH
`define RGB_MEDIAN3X3_FILTER_UNIT_MACROS_SVH

// same-cycle implication
`define RMF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RMF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/rmf_pkg.sv -----
package rmf_pkg;
	localparam int ROW_W = 12;
	localparam int MAX_LINES = 4096;
	localparam int IW_W = 11;
	localparam int IH_W = 13;
	localparam int CFG_DATA_W = 13;
	localparam int RESET_WIDTH = 640;
	localparam int RESET_HEIGHT = 480;

	typedef logic [7:0] chan_t;
	typedef struct packed {
		chan_t red;
		chan_t green;
		chan_t blue;
	} rgb_t;
	typedef chan_t [2:0][2:0] win_t;
	typedef logic [1:0] slot_t;
	typedef logic [ROW_W-1:0] row_t;
	typedef struct packed {
		chan_t lo;
		chan_t md;
		chan_t hi;
	} trip_t;
	typedef struct packed {
		logic s3;
		logic s4;
	} lane_en_t;

	typedef logic [0:0] cfg_idx_t;
	localparam cfg_idx_t CFG_WIDTH = 1'b0;
	localparam cfg_idx_t CFG_HEIGHT = 1'b1;
	localparam logic CMD_PIXEL = 1'b0;

	function automatic slot_t slot_next(slot_t s);
		return (s == 2'd2) ? 2'd0 : s + 2'd1;
	endfunction

	function automatic slot_t slot_prev(slot_t s);
		return (s == 2'd0) ? 2'd2 : s - 2'd1;
	endfunction

	function automatic chan_t min2(chan_t a, chan_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic chan_t max2(chan_t a, chan_t b);
		return (a > b) ? a : b;
	endfunction

	function automatic chan_t min3(chan_t a, chan_t b, chan_t c);
		return min2(min2(a, b), c);
	endfunction

	function automatic chan_t max3(chan_t a, chan_t b, chan_t c);
		return max2(max2(a, b), c);
	endfunction

	function automatic chan_t med3(chan_t a, chan_t b, chan_t c);
		return max2(min2(a, b), min2(max2(a, b), c));
	endfunction

	function automatic trip_t sort3(chan_t a, chan_t b, chan_t c);
		chan_t x;
		chan_t y;
		chan_t t;
		trip_t r;
		x = min2(a, b);
		y = max2(a, b);
		r.hi = max2(y, c);
		t = min2(y, c);
		r.lo = min2(x, t);
		r.md = max2(x, t);
		return r;
	endfunction
endpackage

// ----- rtl/rmf_if.sv -----
interface rmf_in_if;
	logic valid;
	logic ready;
	logic command;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	modport source(output valid, command, red, green, blue, input ready);
	modport sink(input valid, command, red, green, blue, output ready);
endinterface

interface rmf_out_if;
	logic valid;
	logic ready;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;
	logic frame_end;
	modport source(output valid, red_out, green_out, blue_out, frame_end, input ready);
	modport sink(input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

// ----- rtl/rmf_line_bank.sv -----
module rmf_line_bank #(
	parameter int DEPTH = 1024,
	parameter int AW = 10
) (
	input  logic           clk,
	input  logic           we,
	input  logic [AW-1:0]  waddr,
	input  rmf_pkg::rgb_t  wdata,
	input  logic           re,
	input  logic [AW-1:0]  raddr_a,
	input  logic [AW-1:0]  raddr_b,
	output rmf_pkg::rgb_t  rdata_a,
	output rmf_pkg::rgb_t  rdata_b
);
	import rmf_pkg::*;

	rgb_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end
endmodule

// ----- rtl/rmf_median_lane.sv -----
module rmf_median_lane (
	input  logic               clk,
	input  rmf_pkg::lane_en_t  en,
	input  rmf_pkg::win_t      win,
	output rmf_pkg::chan_t     med
);
	import rmf_pkg::*;

	trip_t srt_s3 [3];
	chan_t lmax_s4;
	chan_t mmed_s4;
	chan_t hmin_s4;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			for (int i = 0; i < 3; i++) begin
				srt_s3[i] <= sort3(win[i][0], win[i][1], win[i][2]);
			end
		end
		if (en.s4) begin
			lmax_s4 <= max3(srt_s3[0].lo, srt_s3[1].lo, srt_s3[2].lo);
			mmed_s4 <= med3(srt_s3[0].md, srt_s3[1].md, srt_s3[2].md);
			hmin_s4 <= min3(srt_s3[0].hi, srt_s3[1].hi, srt_s3[2].hi);
		end
	end

	assign med = med3(lmax_s4, mmed_s4, hmin_s4);
endmodule

// ----- rtl/rgb_median3x3_filter_unit.sv -----
// 3x3 median filter on a raster stream of 24-bit RGB pixels, per channel.
// pix_in carries a command bit (pixel or drain tick) and the pixel; pix_out
// carries the filtered pixel and frame_end on the last pixel of the frame.
// Edge neighbors are clamped to the nearest pixel inside the frame.
// An item is taken when valid and ready are both high. A pixel item releases
// at most one result, once its whole neighborhood has arrived; after the last
// pixel of a frame, drain items (or further pixel items, which are dropped)
// release the remaining results, one per item.
// Throughput: one item per cycle while the receiver does not stall. A result
// passes these registers after the edge that takes the item releasing it:
// line memory read, window assembly, two compare stages in each of three channel
// lanes, then the last compare into the output register.
// A stalled receiver backs up the pipeline; pix_in.ready falls only when every
// stage holds a result.
// The user must write configuration (cfg_we, cfg_index, cfg_data) only while idle;
// the block does not enforce this. A write restarts the frame. Reset sets width
// 640, height 480, all positions to zero; the line memories are not cleared.
`include "rgb_median3x3_filter_unit_macros.svh"

module rgb_median3x3_filter_unit #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  rmf_pkg::cfg_idx_t                  cfg_index,
	input  logic [rmf_pkg::CFG_DATA_W-1:0]     cfg_data,
	rmf_in_if.sink                             pix_in,
	rmf_out_if.source                          pix_out
);
	import rmf_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);

	typedef logic [CW-1:0] col_t;

	function automatic rgb_t pick(rgb_t d0, rgb_t d1, rgb_t d2, slot_t s);
		case (s)
			2'd0: return d0;
			2'd1: return d1;
			default: return d2;
		endcase
	endfunction

	logic [IW_W-1:0] iw_q;
	logic [IH_W-1:0] ih_q;
	col_t in_col_q, out_col_q;
	row_t in_row_q, out_row_q;
	slot_t in_slot_q, out_slot_q;
	logic in_done_q;

	col_t wl_c, nc_c, x0_c;
	row_t hl_c, nr_c, y0_c;
	logic pixel_c, rdy_c, has_out_c, last_c, acc;
	logic restart_c, at_origin_c;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	logic v1_q, v2_q, v3_q, v4_q, v5_q;
	rgb_t pix_c;
	logic [2:0] rm_c, cm_c;

	always_comb begin
		if (iw_q == '0) begin
			wl_c = '0;
		end else if ({2'b00, iw_q} > 13'(MAX_WIDTH)) begin
			wl_c = CW'(MAX_WIDTH - 1);
		end else begin
			wl_c = CW'(iw_q - 11'd1);
		end
		if (ih_q == '0) begin
			hl_c = '0;
		end else if (ih_q > 13'(MAX_LINES)) begin
			hl_c = ROW_W'(MAX_LINES - 1);
		end else begin
			hl_c = ROW_W'(ih_q - 13'd1);
		end
	end

	assign pix_c = '{red: pix_in.red, green: pix_in.green, blue: pix_in.blue};
	assign nr_c = (out_row_q < hl_c) ? out_row_q + 12'd1 : hl_c;
	assign nc_c = (out_col_q < wl_c) ? out_col_q + col_t'(1) : wl_c;
	assign y0_c = (out_row_q != '0) ? out_row_q - 12'd1 : '0;
	assign x0_c = (out_col_q != '0) ? out_col_q - col_t'(1) : '0;
	assign pixel_c = (pix_in.command == CMD_PIXEL) && !in_done_q;
	assign rdy_c = (nr_c < in_row_q) || ((nr_c == in_row_q) && (nc_c <= in_col_q));
	assign has_out_c = pixel_c ? rdy_c : in_done_q;
	assign last_c = (out_row_q == hl_c) && (out_col_q == wl_c);
	assign acc = pix_in.valid && rdy1;
	assign restart_c = acc && has_out_c && last_c;
	assign at_origin_c = (out_row_q == '0) && (out_col_q == '0) && !in_done_q;

	assign rm_c[0] = pixel_c && (in_row_q == y0_c);
	assign rm_c[1] = pixel_c && (in_row_q == out_row_q);
	assign rm_c[2] = pixel_c && (in_row_q == nr_c);
	assign cm_c[0] = (in_col_q == x0_c);
	assign cm_c[1] = (in_col_q == out_col_q);
	assign cm_c[2] = (in_col_q == nc_c);

	assign rdy5 = !v5_q || pix_out.ready;
	assign rdy4 = !v4_q || rdy5;
	assign rdy3 = !v3_q || rdy4;
	assign rdy2 = !v2_q || rdy3;
	assign rdy1 = !v1_q || rdy2;
	assign pix_in.ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iw_q <= IW_W'(RESET_WIDTH);
			ih_q <= IH_W'(RESET_HEIGHT);
			in_col_q <= '0;
			in_row_q <= '0;
			in_slot_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			out_slot_q <= '0;
			in_done_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WIDTH: iw_q <= cfg_data[IW_W-1:0];
				CFG_HEIGHT: ih_q <= cfg_data;
				default: ;
			endcase
			in_col_q <= '0;
			in_row_q <= '0;
			in_slot_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			out_slot_q <= '0;
			in_done_q <= 1'b0;
		end else if (restart_c) begin
			in_col_q <= '0;
			in_row_q <= '0;
			in_slot_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			out_slot_q <= '0;
			in_done_q <= 1'b0;
		end else if (acc) begin
			if (pixel_c) begin
				if (in_col_q == wl_c) begin
					in_col_q <= '0;
					if (in_row_q == hl_c) begin
						in_row_q <= '0;
						in_slot_q <= '0;
						in_done_q <= 1'b1;
					end else begin
						in_row_q <= in_row_q + 12'd1;
						in_slot_q <= slot_next(in_slot_q);
					end
				end else begin
					in_col_q <= in_col_q + col_t'(1);
				end
			end
			if (has_out_c) begin
				if (out_col_q == wl_c) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + 12'd1;
					out_slot_q <= slot_next(out_slot_q);
				end else begin
					out_col_q <= out_col_q + col_t'(1);
				end
			end
		end
	end

	// line memories, one per line slot
	rgb_t rd_a [3];
	rgb_t rd_b [3];

	for (genvar k = 0; k < 3; k++) begin : g_bank
		rmf_line_bank #(
			.DEPTH(MAX_WIDTH),
			.AW(CW)
		) u_bank (
			.clk(clk),
			.we(acc && pixel_c && (in_slot_q == slot_t'(k))),
			.waddr(in_col_q),
			.wdata(pix_c),
			.re(rdy1),
			.raddr_a(out_col_q),
			.raddr_b(nc_c),
			.rdata_a(rd_a[k]),
			.rdata_b(rd_b[k])
		);
	end

	// stage 1: control beside the memory read
	rgb_t pix_s1;
	logic [2:0] rm_s1, cm_s1;
	slot_t rsel_s1 [3];
	logic use_prev_s1, last_s1;

	always_ff @(posedge clk) begin
		if (rdy1) begin
			pix_s1 <= pix_c;
			rm_s1 <= rm_c;
			cm_s1 <= cm_c;
			rsel_s1[0] <= (out_row_q != '0) ? slot_prev(out_slot_q) : out_slot_q;
			rsel_s1[1] <= out_slot_q;
			rsel_s1[2] <= (out_row_q < hl_c) ? slot_next(out_slot_q) : out_slot_q;
			use_prev_s1 <= (out_col_q != '0);
			last_s1 <= last_c;
		end
	end

	// stage 2: window assembly; left column reuses the previous center column
	rgb_t pmid_q [3];
	rgb_t win_c [3][3];
	rgb_t w_s2 [3][3];
	logic last_s2, last_s3, last_s4;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			win_c[i][1] = pick(rd_a[0], rd_a[1], rd_a[2], rsel_s1[i]);
			win_c[i][2] = pick(rd_b[0], rd_b[1], rd_b[2], rsel_s1[i]);
			win_c[i][0] = use_prev_s1 ? pmid_q[i] : win_c[i][1];
			for (int j = 0; j < 3; j++) begin
				if (rm_s1[i] && cm_s1[j]) begin
					win_c[i][j] = pix_s1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v1_q && rdy2) begin
			for (int i = 0; i < 3; i++) begin
				pmid_q[i] <= win_c[i][1];
			end
		end
		if (rdy2) begin
			w_s2 <= win_c;
			last_s2 <= last_s1;
		end
		if (rdy3) begin
			last_s3 <= last_s2;
		end
		if (rdy4) begin
			last_s4 <= last_s3;
		end
	end

	// channel lanes
	win_t win_r, win_g, win_b;
	chan_t med_r, med_g, med_b;
	lane_en_t lane_en;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				win_r[i][j] = w_s2[i][j].red;
				win_g[i][j] = w_s2[i][j].green;
				win_b[i][j] = w_s2[i][j].blue;
			end
		end
	end

	assign lane_en = '{s3: rdy3, s4: rdy4};

	rmf_median_lane u_lane_r (.clk(clk), .en(lane_en), .win(win_r), .med(med_r));
	rmf_median_lane u_lane_g (.clk(clk), .en(lane_en), .win(win_g), .med(med_g));
	rmf_median_lane u_lane_b (.clk(clk), .en(lane_en), .win(win_b), .med(med_b));

	// merge into the output register
	chan_t red_q, green_q, blue_q;
	logic frame_end_q;

	always_ff @(posedge clk) begin
		if (rdy5) begin
			red_q <= med_r;
			green_q <= med_g;
			blue_q <= med_b;
			frame_end_q <= last_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
			v5_q <= 1'b0;
		end else begin
			if (rdy1) begin
				v1_q <= acc && has_out_c;
			end
			if (rdy2) begin
				v2_q <= v1_q;
			end
			if (rdy3) begin
				v3_q <= v2_q;
			end
			if (rdy4) begin
				v4_q <= v3_q;
			end
			if (rdy5) begin
				v5_q <= v4_q;
			end
		end
	end

	assign pix_out.valid = v5_q;
	assign pix_out.red_out = red_q;
	assign pix_out.green_out = green_q;
	assign pix_out.blue_out = blue_q;
	assign pix_out.frame_end = frame_end_q;

	`RMF_ASSERT_IMP(a_done_pos, in_done_q, (in_row_q == '0) && (in_col_q == '0), "input not parked")
	`RMF_ASSERT_IMP(a_out_behind, !in_done_q, out_row_q <= in_row_q, "output row ahead of input")
	`RMF_ASSERT_NXT(a_frame_restart, restart_c && !cfg_we, at_origin_c, "frame did not restart")
endmodule

// ----- dv/rgb_median3x3_filter_unit_tb.sv -----
module rgb_median3x3_filter_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rmf_pkg::*;

	localparam int LINE_MAX = 1024;
	localparam int STALL_LIMIT = 20000;

	typedef struct packed {
		rgb_t px;
		logic fe;
	} median_px_t;

	class median_scoreboard;
		int unsigned width_reg = RESET_WIDTH;
		int unsigned height_reg = RESET_HEIGHT;
		rgb_t line_mem[3][LINE_MAX];
		int unsigned in_col, in_row, out_col, out_row;
		bit in_done;
		int unsigned frames;
		int errors;
		median_px_t owed[$];

		function int unsigned eff_w();
			if (width_reg < 1) return 1;
			if (width_reg > LINE_MAX) return LINE_MAX;
			return width_reg;
		endfunction

		function int unsigned eff_h();
			if (height_reg < 1) return 1;
			if (height_reg > MAX_LINES) return MAX_LINES;
			return height_reg;
		endfunction

		function void restart();
			in_col = 0;
			in_row = 0;
			out_col = 0;
			out_row = 0;
			in_done = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
			if (idx == CFG_WIDTH) width_reg = val[IW_W-1:0];
			else height_reg = val[IH_W-1:0];
			restart();
		endfunction

		function chan_t med_of_nine(chan_t v[9]);
			chan_t t;
			int j;
			for (int i = 1; i < 9; i++) begin
				t = v[i];
				j = i - 1;
				while (j >= 0 && v[j] > t) begin
					v[j+1] = v[j];
					j--;
				end
				v[j+1] = t;
			end
			return v[4];
		endfunction

		function int unsigned clamp(int v, int unsigned n);
			if (v < 0) return 0;
			if (v >= int'(n)) return n - 1;
			return v;
		endfunction

		function void predict_window(bit bypass, rgb_t pix);
			chan_t r[9], g[9], b[9];
			int unsigned w, h, y, x;
			int k;
			rgb_t p;
			median_px_t res;
			w = eff_w();
			h = eff_h();
			k = 0;
			for (int dy = -1; dy <= 1; dy++)
				for (int dx = -1; dx <= 1; dx++) begin
					y = clamp(int'(out_row) + dy, h);
					x = clamp(int'(out_col) + dx, w);
					if (bypass && y == in_row && x == in_col) p = pix;
					else p = line_mem[y % 3][x];
					r[k] = p.red;
					g[k] = p.green;
					b[k] = p.blue;
					k++;
				end
			res.px.red = med_of_nine(r);
			res.px.green = med_of_nine(g);
			res.px.blue = med_of_nine(b);
			res.fe = (out_row == h - 1 && out_col == w - 1);
			owed.push_back(res);
		endfunction

		function void note_input(logic cmd, rgb_t pix);
			int unsigned w, h, nr, nc;
			bit released;
			w = eff_w();
			h = eff_h();
			released = 0;
			if (cmd == CMD_PIXEL && !in_done) begin
				nr = (out_row + 1 < h) ? out_row + 1 : h - 1;
				nc = (out_col + 1 < w) ? out_col + 1 : w - 1;
				if (nr < in_row || (nr == in_row && nc <= in_col)) begin
					predict_window(1, pix);
					released = 1;
				end
				line_mem[in_row % 3][in_col] = pix;
				in_col++;
				if (in_col >= w) begin
					in_col = 0;
					in_row++;
					if (in_row >= h) begin
						in_row = 0;
						in_done = 1;
					end
				end
			end else if (in_done) begin
				predict_window(0, pix);
				released = 1;
			end
			if (released) begin
				out_col++;
				if (out_col >= w) begin
					out_col = 0;
					out_row++;
					if (out_row >= h) begin
						restart();
						frames++;
					end
				end
			end
		endfunction

		function void check_result(median_px_t got);
			median_px_t exp_px;
			if (owed.size() == 0) begin
				$display("%0t: unexpected result %h", $realtime, got);
				errors++;
				return;
			end
			exp_px = owed.pop_front();
			if (got.px.red !== exp_px.px.red) begin
				$display("%0t: red_out exp %0d got %0d", $realtime, exp_px.px.red, got.px.red);
				errors++;
			end
			if (got.px.green !== exp_px.px.green) begin
				$display("%0t: green_out exp %0d got %0d", $realtime,
					exp_px.px.green, got.px.green);
				errors++;
			end
			if (got.px.blue !== exp_px.px.blue) begin
				$display("%0t: blue_out exp %0d got %0d", $realtime,
					exp_px.px.blue, got.px.blue);
				errors++;
			end
			if (got.fe !== exp_px.fe) begin
				$display("%0t: frame_end exp %0b got %0b", $realtime, exp_px.fe, got.fe);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	cfg_idx_t cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	rmf_in_if pin();
	rmf_out_if pout();

	median_scoreboard sb = new();
	bit no_idle;
	int stall_left;
	int quiet_cycles;
	int random_items;
	int pix_mode;

	rgb_median3x3_filter_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pix_in(pin.sink),
		.pix_out(pout.source)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function int gap_len();
		int r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function chan_t pick_chan();
		if (pix_mode == 0) return $urandom_range(0, 255);
		case ($urandom_range(0, 3))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'd128;
			default: return $urandom_range(0, 255);
		endcase
	endfunction

	// output side: check, then random stalls; also the watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (pout.valid && pout.ready) begin
				sb.check_result({pout.red_out, pout.green_out, pout.blue_out,
					pout.frame_end});
			end
			if ((pout.valid && pout.ready) || (pin.valid && pin.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				pout.ready <= 0;
			end else begin
				pout.ready <= 1;
				stall_left <= gap_len();
			end
		end
	end

	task automatic send_item(logic cmd, rgb_t pix);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			pin.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		pin.valid <= 1;
		pin.command <= cmd;
		pin.red <= pix.red;
		pin.green <= pix.green;
		pin.blue <= pix.blue;
		do @(posedge clk); while (!pin.ready);
		sb.note_input(cmd, pix);
	endtask

	task automatic wait_idle();
		pin.valid <= 0;
		@(posedge clk);
		while (sb.owed.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_cfg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
		wait_idle();
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		sb.write_reg(idx, val);
	endtask

	// stop_after = 0 runs the frame to its end
	task automatic run_frame(int stop_after);
		int unsigned start;
		int n;
		logic cmd;
		rgb_t pix;
		start = sb.frames;
		n = 0;
		no_idle = ($urandom_range(0, 3) == 0);
		pix_mode = $urandom_range(0, 1);
		while (sb.frames == start && (stop_after == 0 || n < stop_after)) begin
			if (!sb.in_done) cmd = ($urandom_range(0, 99) < 7) ? 1'b1 : CMD_PIXEL;
			else cmd = ($urandom_range(0, 99) < 80) ? 1'b1 : CMD_PIXEL;
			pix = {pick_chan(), pick_chan(), pick_chan()};
			send_item(cmd, pix);
			n++;
		end
		random_items += n;
	endtask

	task automatic set_size(int w, int h);
		write_cfg(CFG_WIDTH, w);
		write_cfg(CFG_HEIGHT, h);
	endtask

	initial begin
		int w;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = CFG_WIDTH;
		cfg_data = '0;
		pin.valid = 0;
		pin.command = CMD_PIXEL;
		pin.red = 0;
		pin.green = 0;
		pin.blue = 0;
		pout.ready = 0;
		stall_left = 0;
		quiet_cycles = 0;
		random_items = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: small and oversized frames, extreme values, drains early, pixels late
		set_size(3, 3);
		pix_mode = 1;
		no_idle = 1;
		send_item(1'b1, 24'h000000);
		send_item(CMD_PIXEL, 24'hFFFFFF);
		send_item(CMD_PIXEL, 24'h000000);
		send_item(CMD_PIXEL, 24'hFF00FF);
		send_item(CMD_PIXEL, 24'h00FF00);
		send_item(CMD_PIXEL, 24'h808080);
		send_item(CMD_PIXEL, 24'h7F7F7F);
		send_item(CMD_PIXEL, 24'h010203);
		send_item(CMD_PIXEL, 24'hFEFDFC);
		send_item(CMD_PIXEL, 24'hAA55AA);
		send_item(CMD_PIXEL, 24'h123456);
		send_item(CMD_PIXEL, 24'hFFFFFF);
		while (sb.in_done) send_item(1'b1, 24'h000000);
		set_size(0, 0);
		run_frame(0);
		run_frame(0);
		set_size(1, 1);
		run_frame(0);
		set_size(2, 5);
		run_frame(0);
		set_size(6, 1);
		run_frame(0);
		set_size(2047, 1);
		run_frame(0);
		set_size(0, 8191);
		run_frame(20);
		set_size(4, 4096);
		run_frame(10);

		while (random_items < 1600) begin
			w = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
			if ($urandom_range(0, 3) == 0)
				write_cfg(CFG_WIDTH, w | ($urandom_range(0, 3) << IW_W));
			else
				write_cfg(CFG_WIDTH, w);
			write_cfg(CFG_HEIGHT, $urandom_range(1, 8));
			repeat ($urandom_range(1, 3)) run_frame(0);
			if ($urandom_range(0, 4) == 0)
				run_frame($urandom_range(1, 30));
		end

		wait_idle();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.owed.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
